@@ sv/prfu_pkg.sv @@
// Shared types, codes and the microcode program of the packed byte rectangle fill unit.
package prfu_pkg;

   localparam int STEP_W = 4;

   // Command codes carried in the opcode field
   localparam logic [1:0] OPC_FILL = 2'd0;
   localparam logic [1:0] OPC_SET  = 2'd1;
   localparam logic [1:0] OPC_READ = 2'd2;

   typedef enum logic [3:0] {
      UOP_NONE,
      UOP_LOAD,
      UOP_SETUP,
      UOP_PIX_ADDR,
      UOP_ROW_START,
      UOP_RD_P,
      UOP_WR_BYTE,
      UOP_WR_PAIR,
      UOP_ROW_NEXT,
      UOP_CAP_WORD,
      UOP_PUSH
   } uop_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_IS_FILL,
      COND_IS_SET,
      COND_PIX_SKIP,
      COND_FILL_SKIP,
      COND_NO_LEAD,
      COND_NO_PAIR,
      COND_MORE_PAIR,
      COND_NO_TRAIL,
      COND_MORE_ROWS,
      COND_OUT_FULL
   } cond_type;

   typedef struct packed {
      uop_type            uop;
      cond_type           cond;
      logic [STEP_W-1:0]  target;
   } ctrl_word_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic is_fill;
      logic is_set;
      logic pix_skip;
      logic fill_skip;
      logic lead;
      logic pair;
      logic more_pair;
      logic trail;
      logic more_rows;
   } dp_flags_type;

   // Program addresses
   localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
   localparam logic [STEP_W-1:0] S_SETUP    = 4'd1;
   localparam logic [STEP_W-1:0] S_PIX      = 4'd2;
   localparam logic [STEP_W-1:0] S_PIX_RD   = 4'd3;
   localparam logic [STEP_W-1:0] S_PIX_CAP  = 4'd4;
   localparam logic [STEP_W-1:0] S_PIX_WR   = 4'd5;
   localparam logic [STEP_W-1:0] S_FILL_CHK = 4'd6;
   localparam logic [STEP_W-1:0] S_ROW      = 4'd7;
   localparam logic [STEP_W-1:0] S_LEAD_RD  = 4'd8;
   localparam logic [STEP_W-1:0] S_LEAD_WR  = 4'd9;
   localparam logic [STEP_W-1:0] S_BODY_CHK = 4'd10;
   localparam logic [STEP_W-1:0] S_BODY     = 4'd11;
   localparam logic [STEP_W-1:0] S_TRAIL_RD = 4'd12;
   localparam logic [STEP_W-1:0] S_TRAIL_WR = 4'd13;
   localparam logic [STEP_W-1:0] S_ROW_NEXT = 4'd14;
   localparam logic [STEP_W-1:0] S_RESP     = 4'd15;

   // Control store: jump to target when the condition holds, else step on.
   // The last step wraps to the idle step.
   function automatic ctrl_word_type ucode_word(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '{uop: UOP_NONE, cond: COND_NEVER, target: S_IDLE};
      case (step)
         S_IDLE:     w = '{uop: UOP_LOAD,      cond: COND_NO_REQ,    target: S_IDLE};
         S_SETUP:    w = '{uop: UOP_SETUP,     cond: COND_IS_FILL,   target: S_FILL_CHK};
         S_PIX:      w = '{uop: UOP_PIX_ADDR,  cond: COND_PIX_SKIP,  target: S_RESP};
         S_PIX_RD:   w = '{uop: UOP_RD_P,      cond: COND_IS_SET,    target: S_PIX_WR};
         S_PIX_CAP:  w = '{uop: UOP_CAP_WORD,  cond: COND_ALWAYS,    target: S_RESP};
         S_PIX_WR:   w = '{uop: UOP_WR_BYTE,   cond: COND_ALWAYS,    target: S_RESP};
         S_FILL_CHK: w = '{uop: UOP_NONE,      cond: COND_FILL_SKIP, target: S_RESP};
         S_ROW:      w = '{uop: UOP_ROW_START, cond: COND_NEVER,     target: S_IDLE};
         S_LEAD_RD:  w = '{uop: UOP_RD_P,      cond: COND_NO_LEAD,   target: S_BODY_CHK};
         S_LEAD_WR:  w = '{uop: UOP_WR_BYTE,   cond: COND_NEVER,     target: S_IDLE};
         S_BODY_CHK: w = '{uop: UOP_NONE,      cond: COND_NO_PAIR,   target: S_TRAIL_RD};
         S_BODY:     w = '{uop: UOP_WR_PAIR,   cond: COND_MORE_PAIR, target: S_BODY};
         S_TRAIL_RD: w = '{uop: UOP_RD_P,      cond: COND_NO_TRAIL,  target: S_ROW_NEXT};
         S_TRAIL_WR: w = '{uop: UOP_WR_BYTE,   cond: COND_NEVER,     target: S_IDLE};
         S_ROW_NEXT: w = '{uop: UOP_ROW_NEXT,  cond: COND_MORE_ROWS, target: S_ROW};
         S_RESP:     w = '{uop: UOP_PUSH,      cond: COND_OUT_FULL,  target: S_RESP};
         default:    w = '{uop: UOP_NONE,      cond: COND_ALWAYS,    target: S_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ sv/prfu_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jump condition select.
module prfu_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    out_full,
   input  prfu_pkg::dp_flags_type  flags,
   output prfu_pkg::ctrl_word_type ctrl,
   output logic                    idle
);

   logic [prfu_pkg::STEP_W-1:0] upc_ff;
   logic [prfu_pkg::STEP_W-1:0] upc_in;
   logic                        take;

   always_comb begin
      ctrl = prfu_pkg::ucode_word(upc_ff);
      idle = (upc_ff == prfu_pkg::S_IDLE);
   end

   always_comb begin
      case (ctrl.cond)
         prfu_pkg::COND_NEVER:     take = 1'b0;
         prfu_pkg::COND_ALWAYS:    take = 1'b1;
         prfu_pkg::COND_NO_REQ:    take = !req_tvalid;
         prfu_pkg::COND_IS_FILL:   take = flags.is_fill;
         prfu_pkg::COND_IS_SET:    take = flags.is_set;
         prfu_pkg::COND_PIX_SKIP:  take = flags.pix_skip;
         prfu_pkg::COND_FILL_SKIP: take = flags.fill_skip;
         prfu_pkg::COND_NO_LEAD:   take = !flags.lead;
         prfu_pkg::COND_NO_PAIR:   take = !flags.pair;
         prfu_pkg::COND_MORE_PAIR: take = flags.more_pair;
         prfu_pkg::COND_NO_TRAIL:  take = !flags.trail;
         prfu_pkg::COND_MORE_ROWS: take = flags.more_rows;
         prfu_pkg::COND_OUT_FULL:  take = out_full;
         default:                  take = 1'b0;
      endcase
      upc_in = take ? ctrl.target : upc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= prfu_pkg::S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

@@ sv/prfu_dp.sv @@
// Datapath: command registers, pixel pointers, row counter and the packed frame memory.
module prfu_dp #(
   parameter int SCREEN_WIDTH  = 240,
   parameter int SCREEN_HEIGHT = 160
) (
   input  logic                    clock,
   input  prfu_pkg::ctrl_word_type ctrl,
   input  logic                    req_fire,
   input  logic [1:0]              in_opcode,
   input  logic [7:0]              in_column,
   input  logic [7:0]              in_line,
   input  logic [7:0]              in_rect_width,
   input  logic [7:0]              in_rect_height,
   input  logic [7:0]              in_color_index,
   output prfu_pkg::dp_flags_type  flags,
   output logic [15:0]             read_word,
   output logic                    status
);

   localparam int NPIX  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int DEPTH = (NPIX + 1) / 2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = $clog2(NPIX + 1);
   localparam int XW    = $clog2(SCREEN_WIDTH + 512);
   localparam int YW    = $clog2(SCREEN_HEIGHT + 512);

   logic [15:0]   frame_mem [DEPTH];

   logic [1:0]    opcode_ff;
   logic [7:0]    column_ff;
   logic [7:0]    line_ff;
   logic [7:0]    width_ff;
   logic [7:0]    height_ff;
   logic [7:0]    color_ff;

   logic [PW-1:0] rowbase_ff;
   logic [PW-1:0] p_ff;
   logic [PW-1:0] pe_ff;
   logic [XW-1:0] xend_ff;
   logic [YW-1:0] yend_ff;
   logic [YW-1:0] row_ff;
   logic          fill_skip_ff;
   logic          pix_skip_ff;
   logic          status_ff;
   logic [15:0]   word_ff;
   logic [15:0]   rd_q_ff;

   logic [XW-1:0] x_sum;
   logic [YW-1:0] y_sum;
   logic          clip_x;
   logic          clip_y;
   logic [XW-1:0] x_end;
   logic [YW-1:0] y_end;
   logic          empty;
   logic          on_screen;
   logic [AW-1:0] addr;
   logic [15:0]   wdata;
   logic          we;

   // Clip the rectangle to the screen
   always_comb begin
      x_sum     = XW'(column_ff) + XW'(width_ff);
      y_sum     = YW'(line_ff) + YW'(height_ff);
      clip_x    = x_sum > XW'(SCREEN_WIDTH);
      clip_y    = y_sum > YW'(SCREEN_HEIGHT);
      x_end     = clip_x ? XW'(SCREEN_WIDTH) : x_sum;
      y_end     = clip_y ? YW'(SCREEN_HEIGHT) : y_sum;
      empty     = (width_ff == 8'd0) || (height_ff == 8'd0);
      on_screen = (XW'(column_ff) < XW'(SCREEN_WIDTH)) && (YW'(line_ff) < YW'(SCREEN_HEIGHT));
   end

   always_comb begin
      flags.is_fill   = (opcode_ff == prfu_pkg::OPC_FILL);
      flags.is_set    = (opcode_ff == prfu_pkg::OPC_SET);
      flags.pix_skip  = pix_skip_ff;
      flags.fill_skip = fill_skip_ff;
      flags.lead      = p_ff[0] && (p_ff < pe_ff);
      flags.pair      = (PW'(p_ff) + (PW+2)'(1)) < (PW+2)'(pe_ff);
      flags.more_pair = (PW'(p_ff) + (PW+2)'(3)) < (PW+2)'(pe_ff);
      flags.trail     = p_ff < pe_ff;
      flags.more_rows = ((YW+1)'(row_ff) + (YW+1)'(1)) < (YW+1)'(yend_ff);
      read_word       = word_ff;
      status          = status_ff;
   end

   // Memory port: odd pixel in the high byte, even pixel in the low byte
   always_comb begin
      addr  = AW'(p_ff >> 1);
      we    = (ctrl.uop == prfu_pkg::UOP_WR_BYTE) || (ctrl.uop == prfu_pkg::UOP_WR_PAIR);
      if (ctrl.uop == prfu_pkg::UOP_WR_PAIR) begin
         wdata = {color_ff, color_ff};
      end else if (p_ff[0]) begin
         wdata = {color_ff, rd_q_ff[7:0]};
      end else begin
         wdata = {rd_q_ff[15:8], color_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         frame_mem[addr] <= wdata;
      end
      if (ctrl.uop == prfu_pkg::UOP_RD_P) begin
         rd_q_ff <= frame_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      case (ctrl.uop)
         prfu_pkg::UOP_LOAD: begin
            if (req_fire) begin
               opcode_ff <= in_opcode;
               column_ff <= in_column;
               line_ff   <= in_line;
               width_ff  <= in_rect_width;
               height_ff <= in_rect_height;
               color_ff  <= in_color_index;
            end
         end
         prfu_pkg::UOP_SETUP: begin
            rowbase_ff   <= PW'(32'(line_ff) * SCREEN_WIDTH);
            row_ff       <= YW'(line_ff);
            xend_ff      <= x_end;
            yend_ff      <= y_end;
            fill_skip_ff <= empty || (XW'(column_ff) >= x_end) || (YW'(line_ff) >= y_end);
            pix_skip_ff  <= (opcode_ff != prfu_pkg::OPC_SET && opcode_ff != prfu_pkg::OPC_READ)
                            || !on_screen;
            word_ff      <= 16'd0;
            if (opcode_ff == prfu_pkg::OPC_FILL) begin
               status_ff <= !empty && (clip_x || clip_y);
            end else if (opcode_ff == prfu_pkg::OPC_SET || opcode_ff == prfu_pkg::OPC_READ) begin
               status_ff <= !on_screen;
            end else begin
               status_ff <= 1'b0;
            end
         end
         prfu_pkg::UOP_PIX_ADDR: begin
            p_ff <= rowbase_ff + PW'(column_ff);
         end
         prfu_pkg::UOP_ROW_START: begin
            p_ff  <= rowbase_ff + PW'(column_ff);
            pe_ff <= rowbase_ff + PW'(xend_ff);
         end
         prfu_pkg::UOP_WR_BYTE: begin
            p_ff <= p_ff + PW'(1);
         end
         prfu_pkg::UOP_WR_PAIR: begin
            p_ff <= p_ff + PW'(2);
         end
         prfu_pkg::UOP_ROW_NEXT: begin
            rowbase_ff <= rowbase_ff + PW'(SCREEN_WIDTH);
            row_ff     <= row_ff + YW'(1);
         end
         prfu_pkg::UOP_CAP_WORD: begin
            word_ff <= rd_q_ff;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ sv/packed_byte_rect_fill_unit.sv @@
// Top level of the packed byte rectangle fill unit: stream ports, sequencer, datapath, result register.
//
// Owns a SCREEN_WIDTH x SCREEN_HEIGHT framebuffer of 8-bit pixels, two to a 16-bit word.
// Each command on the req_ stream (fill rectangle, set pixel, read word) gives one result
// on the rsp_ stream: the word read (zero unless a read) and a clip flag.
// Commands run one at a time under a 16-step microcode program; req_tready is high only
// while the sequencer sits at its idle step.
// Steps: a set pixel or read word computes the pixel address and reads its word, then writes
//   the byte back (set) or captures the word (read) and pushes the result; a fill does a
//   setup step, then per row a row start, a partial leading word read and written back,
//   whole words set by the single memory port writing one word per cycle, a partial
//   trailing word and a row step; empty or off-screen fills and off-screen pixels skip to the push.
// A partial word is read into a register and written back in the next cycle on the same port.
// The result sits in an output register, so a new command is taken while it waits; when
// the receiver stalls with a result still pending, the next command holds at its last
// step until that result is taken.
// Reset returns the sequencer to idle and empties the result register. The framebuffer
// is not cleared; a word must be written before it is read.
module packed_byte_rect_fill_unit #(
   parameter int SCREEN_WIDTH  = 240,
   parameter int SCREEN_HEIGHT = 160
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[1:0], column[9:2], line[17:10], rect_width[25:18], rect_height[33:26],
   // color_index[41:34], zero fill[47:42]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_word[15:0], status[16], zero fill[23:17]
   output logic [23:0] rsp_tdata
);

   prfu_pkg::ctrl_word_type ctrl;
   prfu_pkg::dp_flags_type  flags;

   logic        req_fire;
   logic        out_full;
   logic        push;
   logic [15:0] dp_word;
   logic        dp_status;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_word_ff;
   logic        rsp_status_ff;

   assign req_fire = req_tvalid && req_tready;
   assign out_full = rsp_valid_ff && !rsp_tready;
   assign push     = (ctrl.uop == prfu_pkg::UOP_PUSH) && !out_full;

   prfu_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_full   (out_full),
      .flags      (flags),
      .ctrl       (ctrl),
      .idle       (req_tready)
   );

   prfu_dp #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dp (
      .clock          (clock),
      .ctrl           (ctrl),
      .req_fire       (req_fire),
      .in_opcode      (req_tdata[1:0]),
      .in_column      (req_tdata[9:2]),
      .in_line        (req_tdata[17:10]),
      .in_rect_width  (req_tdata[25:18]),
      .in_rect_height (req_tdata[33:26]),
      .in_color_index (req_tdata[41:34]),
      .flags          (flags),
      .read_word      (dp_word),
      .status         (dp_status)
   );

   // Result register: load on push, drop once transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_word_ff   <= dp_word;
         rsp_status_ff <= dp_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_word_ff};

   // A command transfer starts the program, so the port closes on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("req_tready still high after a command transfer");

   // A clipped result never carries a read word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[15:0] == 16'd0)
      else $error("clipped result with nonzero read word");

   // A result appears only after the program reached its push step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(push))
      else $error("result valid without a push");

endmodule
